// ===== hdl/dq_pkg.sv =====
// Shared types and codes for the double-ended queue.
// Holds the payload structs, operation and status codes, and the
// command/status bundles between controller and datapath. No dependencies.
package dq_pkg;

    localparam int unsigned DataW = 32;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_REAR  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_REAR   = 3'd3;
    localparam logic [2:0] OP_DUMP       = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [2:0]              op;
        logic signed [DataW-1:0] value;
    } item_t;

    typedef struct packed {
        logic [1:0]              status;
        logic                    has_element;
        logic signed [DataW-1:0] element;
        logic                    last;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic       push_front;
        logic       push_rear;
        logic       pop_front;
        logic       pop_rear;
        logic       dump_start;
        logic       load_status;
        logic [1:0] status;
        logic       load_element;
    } dq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic one_left;
        logic out_free;
    } dq_stat_t;

endpackage

// ===== hdl/dq_ctrl.sv =====
// Controller of the double-ended queue: decodes operations and sequences dumps.
// Depends on dq_pkg for the opcodes and the command/status structs.
module dq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  logic [2:0]       op,
    input  dq_pkg::dq_stat_t stat,
    output dq_pkg::dq_cmd_t  cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    logic state_reg;
    logic state_next;
    logic take;

    assign item_ready = (state_reg == S_IDLE) && stat.out_free;
    assign take       = item_valid && item_ready;

    always_comb
    begin
        cmd        = '0;
        cmd.status = dq_pkg::ST_OK;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    case (op)
                        dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_REAR:
                        begin
                            cmd.load_status = 1'b1;
                            if (stat.full)
                            begin
                                cmd.status = dq_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                cmd.push_front = (op == dq_pkg::OP_PUSH_FRONT);
                                cmd.push_rear  = (op == dq_pkg::OP_PUSH_REAR);
                            end
                        end
                        dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_REAR:
                        begin
                            cmd.load_status = 1'b1;
                            if (stat.empty)
                            begin
                                cmd.status = dq_pkg::ST_UNDERFLOW;
                            end
                            else
                            begin
                                cmd.pop_front = (op == dq_pkg::OP_POP_FRONT);
                                cmd.pop_rear  = (op == dq_pkg::OP_POP_REAR);
                            end
                        end
                        dq_pkg::OP_DUMP:
                        begin
                            if (stat.empty)
                            begin
                                cmd.load_status = 1'b1;
                                cmd.status      = dq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.dump_start = 1'b1;
                                state_next     = S_DUMP;
                            end
                        end
                        default:
                        begin
                            // unassigned opcode: drop silently
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                if (stat.out_free)
                begin
                    cmd.load_element = 1'b1;
                    if (stat.one_left)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/dq_path.sv =====
// Datapath of the double-ended queue: ring store, head index, fill count,
// dump walker and result register. Depends on dq_pkg for structs and codes.
module dq_path #(
    parameter int unsigned DEPTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic signed [dq_pkg::DataW-1:0] value,
    input  dq_pkg::dq_cmd_t                cmd,
    output dq_pkg::dq_stat_t               stat,
    output logic                           result_valid,
    input  logic                           result_ready,
    output dq_pkg::result_t                result
);

    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LastIdx = IW'(DEPTH - 1);

    logic [dq_pkg::DataW-1:0] mem [DEPTH];
    logic [dq_pkg::DataW-1:0] rd_data_reg;

    logic [IW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] walk_reg, walk_next;
    logic [CW-1:0] remain_reg, remain_next;
    logic          result_valid_reg, result_valid_next;
    dq_pkg::result_t result_reg;

    logic [IW-1:0] head_dec;
    logic [IW-1:0] head_inc;
    logic [IW-1:0] walk_inc;
    logic [CW:0]   rear_sum;
    logic [IW-1:0] rear_idx;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic          rd_en;
    logic [IW-1:0] rd_addr;

    assign head_dec = (head_reg == '0) ? LastIdx : head_reg - 1'b1;
    assign head_inc = (head_reg == LastIdx) ? '0 : head_reg + 1'b1;
    assign walk_inc = (walk_reg == LastIdx) ? '0 : walk_reg + 1'b1;

    // head + count stays below twice the depth: one compare and subtract wraps it
    assign rear_sum = (CW + 1)'(head_reg) + (CW + 1)'(count_reg);
    assign rear_idx = (rear_sum >= (CW + 1)'(DEPTH)) ? IW'(rear_sum - (CW + 1)'(DEPTH))
                                                     : IW'(rear_sum);

    assign wr_en   = cmd.push_front || cmd.push_rear;
    assign wr_addr = cmd.push_front ? head_dec : rear_idx;
    assign rd_en   = cmd.dump_start || (cmd.load_element && !stat.one_left);
    assign rd_addr = cmd.dump_start ? head_reg : walk_reg;

    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg == CW'(DEPTH));
    assign stat.one_left = (remain_reg == CW'(1));
    assign stat.out_free = !result_valid_reg || result_ready;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.push_front)
        begin
            head_next  = head_dec;
            count_next = count_reg + 1'b1;
        end
        else if (cmd.push_rear)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.pop_front)
        begin
            head_next  = head_inc;
            count_next = count_reg - 1'b1;
        end
        else if (cmd.pop_rear)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        walk_next   = walk_reg;
        remain_next = remain_reg;
        if (cmd.dump_start)
        begin
            walk_next   = head_inc;
            remain_next = count_reg;
        end
        else if (cmd.load_element)
        begin
            remain_next = remain_reg - 1'b1;
            if (!stat.one_left)
            begin
                walk_next = walk_inc;
            end
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (cmd.load_status || cmd.load_element)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg         <= '0;
            count_reg        <= '0;
            walk_reg         <= '0;
            remain_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg         <= head_next;
            count_reg        <= count_next;
            walk_reg         <= walk_next;
            remain_reg       <= remain_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_status)
        begin
            result_reg.status      <= cmd.status;
            result_reg.has_element <= 1'b0;
            result_reg.element     <= '0;
            result_reg.last        <= 1'b1;
        end
        else if (cmd.load_element)
        begin
            result_reg.status      <= dq_pkg::ST_OK;
            result_reg.has_element <= 1'b1;
            result_reg.element     <= rd_data_reg;
            result_reg.last        <= stat.one_left;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== hdl/double_ended_queue.sv =====
// Bounded double-ended queue of signed 32-bit values, DEPTH entries.
// Channels: item (op, value) in, result (status, has_element, element, last)
// out, both valid/ready; a transfer happens when valid and ready are high.
// Push and pop ops give one status result (overflow when full, underflow
// when empty, state unchanged then). Dump gives every held element front to
// rear with last on the final one, or a single empty status. Opcodes five to
// seven are taken and dropped with no result.
// Timing: a result shows in the cycle after the item transfer; the first
// dumped element passes the store read register, then the result register.
// Throughput: one push/pop per cycle while results are taken; a dump reads
// its elements one at a time from the one registered read port of the ring
// store, and no item is taken during it. Stall: the result register holds
// until taken; item_ready drops while it is full and not being taken, and a
// dump pauses. Reset: rst_n clears head, count and result valid; the store
// needs no clear since only pushed entries are ever read.
// Depends on dq_pkg, dq_ctrl, dq_path.
module double_ended_queue #(
    parameter int unsigned DEPTH = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  dq_pkg::item_t   item,
    output logic            result_valid,
    input  logic            result_ready,
    output dq_pkg::result_t result
);

    dq_pkg::dq_cmd_t  cmd;
    dq_pkg::dq_stat_t stat;

    dq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .op         (item.op),
        .stat       (stat),
        .cmd        (cmd)
    );

    dq_path #(
        .DEPTH (DEPTH)
    ) u_path (
        .clk          (clk),
        .rst_n        (rst_n),
        .value        (item.value),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ===== bench/tb_top.sv =====
// Testbench for double_ended_queue: a scripted walk through the empty, full and
// wrap-around cases, then random operation mixes, checked by a ring-store predictor.
// Depends on dq_pkg and the double_ended_queue RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int Depth = 32;
    localparam int RingIw = $clog2(Depth);
    localparam int RandomOps = 60;
    localparam int PhaseOps = 30;
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;

    typedef struct packed {
        logic [2:0]        op;
        logic signed [31:0] value;
        logic [5:0]        reps;
        logic              checked;
        logic [1:0]        status;
    } step_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            item_valid = 1'b0;
    logic            item_ready;
    dq_pkg::item_t   item = '0;
    logic            result_valid;
    logic            result_ready = 1'b0;
    dq_pkg::result_t result;

    // predictor state
    logic signed [dq_pkg::DataW-1:0] ring [Depth];
    int              ring_head = 0;
    int              ring_count = 0;
    dq_pkg::result_t pending_results[$];
    step_t           script[$];

    int errors = 0;
    int ops_sent = 0;
    int dumps_sent = 0;
    int results_seen = 0;
    int overflows = 0;
    int underflows = 0;
    int tx_burst = 0;
    int rx_burst = 0;
    int stall_left = 0;

    double_ended_queue u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    // Mostly short gaps, a few long ones, and bursts with none at all.
    function automatic int pick_gap(inout int burst);
        int r;
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 6)
        begin
            burst = $urandom_range(10, 30);
            return 0;
        end
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 8);
        return $urandom_range(12, 24);
    endfunction

    // Advance the ring model by one operation and queue the results it gives.
    function automatic void apply_deque_op(input dq_pkg::item_t it);
        dq_pkg::result_t r;
        r.status = dq_pkg::ST_OK;
        r.has_element = 1'b0;
        r.element = '0;
        r.last = 1'b1;
        case (it.op)
            dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_REAR:
            begin
                if (ring_count == Depth)
                begin
                    r.status = dq_pkg::ST_OVERFLOW;
                    overflows++;
                end
                else
                begin
                    if (it.op == dq_pkg::OP_PUSH_FRONT)
                    begin
                        ring_head = (ring_head + Depth - 1) % Depth;
                        ring[RingIw'(ring_head)] = it.value;
                    end
                    else
                        ring[RingIw'((ring_head + ring_count) % Depth)] = it.value;
                    ring_count++;
                end
                pending_results.push_back(r);
            end
            dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_REAR:
            begin
                if (ring_count == 0)
                begin
                    r.status = dq_pkg::ST_UNDERFLOW;
                    underflows++;
                end
                else
                begin
                    if (it.op == dq_pkg::OP_POP_FRONT)
                        ring_head = (ring_head + 1) % Depth;
                    ring_count--;
                end
                pending_results.push_back(r);
            end
            dq_pkg::OP_DUMP:
            begin
                if (ring_count == 0)
                begin
                    r.status = dq_pkg::ST_EMPTY;
                    pending_results.push_back(r);
                end
                else
                begin
                    for (int i = 0; i < ring_count; i++)
                    begin
                        r.has_element = 1'b1;
                        r.element = ring[RingIw'((ring_head + i) % Depth)];
                        r.last = (i == ring_count - 1);
                        pending_results.push_back(r);
                    end
                end
            end
            default: ;  // spare codes: dropped, no result
        endcase
    endfunction

    task automatic send_op(input dq_pkg::item_t it);
        int gap;
        gap = pick_gap(tx_burst);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        apply_deque_op(it);
        if (it.op <= dq_pkg::OP_DUMP)
            ops_sent++;
        if (it.op == dq_pkg::OP_DUMP)
            dumps_sent++;
    endtask

    // Hold off the sender until every queued result has come back.
    task automatic drain_pending();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic add_step(input logic [2:0] op, input logic signed [31:0] value,
                            input int reps, input logic checked, input logic [1:0] status);
        step_t s;
        s.op = op;
        s.value = value;
        s.reps = 6'(reps);
        s.checked = checked;
        s.status = status;
        script.push_back(s);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 19))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return '0;
            3: return '1;
            default: return $urandom();
        endcase
    endfunction

    // Check each result transfer against the oldest expectation; stall at random.
    always @(posedge clk)
    begin
        dq_pkg::result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result status %0d has %0d element %0d last %0d",
                             $time, result.status, result.has_element, result.element,
                             result.last);
            end
            else
            begin
                want = pending_results.pop_front();
                results_seen++;
                if (result.status !== want.status || result.has_element !== want.has_element
                    || result.element !== want.element || result.last !== want.last)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("%0t: mismatch (expected/actual) status %0d/%0d has %0d/%0d",
                                 $time, want.status, result.status, want.has_element,
                                 result.has_element);
                        $display("    element %0d/%0d last %0d/%0d", want.element,
                                 result.element, want.last, result.last);
                    end
                end
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            result_ready <= 1'b0;
        end
        else
        begin
            stall_left = pick_gap(rx_burst);
            result_ready <= (stall_left == 0);
        end
    end

    initial
    begin
        dq_pkg::item_t it;
        int    fill_pct;
        int    phase_ops;
        int    r;

        // Scripted part: extremes, every operation, empty and full corners, wrap both ways.
        add_step(dq_pkg::OP_POP_FRONT, 32'sd0, 1, 1'b1, dq_pkg::ST_UNDERFLOW);
        add_step(dq_pkg::OP_POP_REAR, 32'sd0, 1, 1'b1, dq_pkg::ST_UNDERFLOW);
        add_step(dq_pkg::OP_DUMP, 32'sd0, 1, 1'b1, dq_pkg::ST_EMPTY);
        add_step(dq_pkg::OP_PUSH_FRONT, 32'sh7fffffff, 1, 1'b1, dq_pkg::ST_OK);
        add_step(dq_pkg::OP_PUSH_REAR, 32'sh80000000, 1, 1'b1, dq_pkg::ST_OK);
        add_step(dq_pkg::OP_PUSH_FRONT, -32'sd1, 1, 1'b0, dq_pkg::ST_OK);
        add_step(dq_pkg::OP_PUSH_REAR, 32'sd0, 1, 1'b0, dq_pkg::ST_OK);
        add_step(dq_pkg::OP_DUMP, 32'sd0, 1, 1'b0, dq_pkg::ST_OK);
        add_step(OP_SPARE_FIRST, 32'sh12345678, 1, 1'b0, dq_pkg::ST_OK);
        add_step(OP_SPARE_FIRST + 3'd1, -32'sd1, 1, 1'b0, dq_pkg::ST_OK);
        add_step(OP_SPARE_FIRST + 3'd2, 32'sh80000000, 1, 1'b0, dq_pkg::ST_OK);
        add_step(dq_pkg::OP_DUMP, 32'sd0, 1, 1'b0, dq_pkg::ST_OK);
        add_step(dq_pkg::OP_POP_FRONT, 32'sd0, 1, 1'b1, dq_pkg::ST_OK);
        add_step(dq_pkg::OP_POP_REAR, 32'sd0, 1, 1'b1, dq_pkg::ST_OK);
        add_step(dq_pkg::OP_PUSH_REAR, 32'sh5a5a0000, 30, 1'b0, dq_pkg::ST_OK);
        add_step(dq_pkg::OP_PUSH_FRONT, 32'sh0badf00d, 1, 1'b1, dq_pkg::ST_OVERFLOW);
        add_step(dq_pkg::OP_PUSH_REAR, 32'sh0badf00d, 1, 1'b1, dq_pkg::ST_OVERFLOW);
        add_step(dq_pkg::OP_DUMP, 32'sd0, 1, 1'b0, dq_pkg::ST_OK);
        add_step(dq_pkg::OP_POP_FRONT, 32'sd0, 32, 1'b1, dq_pkg::ST_OK);
        add_step(dq_pkg::OP_POP_REAR, 32'sd0, 1, 1'b1, dq_pkg::ST_UNDERFLOW);
        add_step(dq_pkg::OP_PUSH_FRONT, -32'sd100, 5, 1'b0, dq_pkg::ST_OK);
        add_step(dq_pkg::OP_DUMP, 32'sd0, 1, 1'b0, dq_pkg::ST_OK);
        add_step(dq_pkg::OP_POP_REAR, 32'sd0, 5, 1'b1, dq_pkg::ST_OK);
        add_step(dq_pkg::OP_DUMP, 32'sd0, 1, 1'b1, dq_pkg::ST_EMPTY);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[k])
        begin
            for (int n = 0; n < script[k].reps; n++)
            begin
                it.op = script[k].op;
                it.value = script[k].value + n;
                send_op(it);
                // swap in the hand-written status for rows that carry one
                if (script[k].checked)
                begin
                    pending_results[pending_results.size() - 1].status = script[k].status;
                    pending_results[pending_results.size() - 1].has_element = 1'b0;
                    pending_results[pending_results.size() - 1].element = '0;
                    pending_results[pending_results.size() - 1].last = 1'b1;
                end
            end
        end
        drain_pending();

        // Random part: phases that lean toward filling, draining or neither.
        phase_ops = 0;
        fill_pct = 55;
        for (int counted = 0; counted < RandomOps; )
        begin
            if (phase_ops == 0)
            begin
                case ($urandom_range(0, 2))
                    0: fill_pct = 90;
                    1: fill_pct = 30;
                    default: fill_pct = 55;
                endcase
                phase_ops = PhaseOps;
            end
            if (counted == RandomOps / 2 && phase_ops == PhaseOps)
                drain_pending();
            r = $urandom_range(0, 99);
            it.value = pick_value();
            if (r < 3)
                it.op = OP_SPARE_FIRST + 3'($urandom_range(0, 2));
            else
            begin
                if (r < 13)
                    it.op = dq_pkg::OP_DUMP;
                else if (r < fill_pct)
                    it.op = $urandom_range(0, 1) ? dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_REAR;
                else
                    it.op = $urandom_range(0, 1) ? dq_pkg::OP_POP_FRONT : dq_pkg::OP_POP_REAR;
                counted++;
                phase_ops--;
            end
            send_op(it);
        end

        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Covered %0d operations (%0d dumps), %0d results checked,", ops_sent,
                 dumps_sent, results_seen);
        $display("with %0d overflow and %0d underflow responses; %0d mismatches.", overflows,
                 underflows, errors);
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/dq_pkg.sv
hdl/dq_ctrl.sv
hdl/dq_path.sv
hdl/double_ended_queue.sv
bench/tb_top.sv
